// File: sv/jct_pkg.sv
// Shared types, constants and byte-pair conversion functions for the
// Japanese code transcoder. No dependencies.
`default_nettype none

package jct_pkg;

	// Size of each mapping memory
	localparam int unsigned MAP_ENTRIES_DEF = 65536;
	// Depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH     = 4;
	// Items the block can hold at once: front stage, queue, read stage, output
	localparam int unsigned MAX_INFLIGHT    = QUEUE_DEPTH + 3;

	typedef enum logic [2:0] {
		OP_WR_SJIS_MAP,
		OP_WR_UNI_MAP,
		OP_SJIS_TO_UNI,
		OP_UNI_TO_SJIS,
		OP_JIS_TO_UNI,
		OP_UNI_TO_JIS,
		OP_EUC_TO_UNI,
		OP_UNI_TO_EUC
	} op_t;

	// What the back end does with the word read from a map
	typedef enum logic [1:0] {
		POST_ZERO,
		POST_RAW,
		POST_JIS,
		POST_EUC
	} post_t;

	// One classified beat handed from front to back
	typedef struct packed {
		logic        is_write;
		logic        use_uni;
		post_t       post;
		logic [15:0] addr;
		logic [15:0] word;
	} entry_t;

	// Half-width katakana to full-width JIS
	localparam logic [15:0] KANA_TO_JIS [64] = '{
		16'h2121, 16'h2123, 16'h2156, 16'h2157, 16'h2122, 16'h2126, 16'h2572, 16'h2521,
		16'h2523, 16'h2525, 16'h2527, 16'h2529, 16'h2563, 16'h2565, 16'h2567, 16'h2543,
		16'h213c, 16'h2522, 16'h2524, 16'h2526, 16'h2528, 16'h252a, 16'h252b, 16'h252d,
		16'h252f, 16'h2531, 16'h2533, 16'h2535, 16'h2537, 16'h2539, 16'h253b, 16'h253d,
		16'h253f, 16'h2541, 16'h2544, 16'h2546, 16'h2548, 16'h254a, 16'h254b, 16'h254c,
		16'h254d, 16'h254e, 16'h254f, 16'h2552, 16'h2555, 16'h2558, 16'h255b, 16'h255e,
		16'h255f, 16'h2560, 16'h2561, 16'h2562, 16'h2564, 16'h2566, 16'h2568, 16'h2569,
		16'h256a, 16'h256b, 16'h256c, 16'h256d, 16'h256f, 16'h2573, 16'h212b, 16'h212c
	};

	// EUC-JP to JIS; 0x8E prefix selects half-width katakana
	function automatic logic [15:0] euc_to_jis(input logic [15:0] euc);
		logic [7:0] lo;
		logic [7:0] idx;
		lo  = euc[7:0];
		idx = lo - 8'ha0;
		if (euc[15:8] == 8'h8e) begin
			if (lo < 8'ha0 || lo > 8'hdf) begin
				return 16'h0000;
			end
			return KANA_TO_JIS[idx[5:0]];
		end
		return euc & 16'h7f7f;
	endfunction

	// JIS to SJIS, bytes wrapping modulo 256
	function automatic logic [15:0] jis_to_sjis(input logic [15:0] jis);
		logic [7:0] hi;
		logic [7:0] lo;
		logic [7:0] t;
		hi = jis[15:8];
		lo = jis[7:0] + (hi[0] ? 8'h1f : 8'h7d);
		if (lo >= 8'h7f) begin
			lo = lo + 8'h01;
		end
		t  = hi - 8'h21;
		hi = {1'b0, t[7:1]} + 8'h81;
		if (hi > 8'h9f) begin
			hi = hi + 8'h40;
		end
		return {hi, lo};
	endfunction

	// SJIS lead byte to the odd JIS row byte
	function automatic logic [7:0] sjis_lead_to_row(input logic [7:0] lead);
		logic [7:0] t;
		t = lead - ((lead <= 8'h9f) ? 8'h71 : 8'hb1);
		return {t[6:0], 1'b1};
	endfunction

	function automatic logic [15:0] sjis_to_jis(input logic [15:0] sjis);
		logic [7:0] hi;
		logic [7:0] lo;
		hi = sjis_lead_to_row(sjis[15:8]);
		lo = sjis[7:0];
		if (lo > 8'h7f) begin
			lo = lo - 8'h01;
		end
		if (lo >= 8'h9e) begin
			lo = lo - 8'h7d;
			hi = hi + 8'h01;
		end else begin
			lo = lo - 8'h1f;
		end
		return {hi, lo};
	endfunction

	// Trail byte 0x9F and above selects the even row
	function automatic logic [15:0] sjis_to_euc(input logic [15:0] sjis);
		logic [7:0] hi;
		logic [7:0] lo;
		hi = sjis_lead_to_row(sjis[15:8]);
		lo = sjis[7:0];
		if (lo >= 8'h9f) begin
			lo = lo - 8'h7e;
			hi = hi + 8'h01;
		end else if (lo > 8'h7f) begin
			lo = lo - 8'h20;
		end else begin
			lo = lo - 8'h1f;
		end
		return {hi | 8'h80, lo | 8'h80};
	endfunction

endpackage

`default_nettype wire

// File: sv/jct_intf.sv
// Valid/ready channel interfaces for the transcoder's input and output beats.
// No dependencies.
`default_nettype none

interface jct_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [15:0] code_in;
	logic [15:0] table_word;

	modport source(output valid, operation, code_in, table_word, input ready);
	modport sink(input valid, operation, code_in, table_word, output ready);
endinterface

interface jct_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_out;

	modport source(output valid, code_out, input ready);
	modport sink(input valid, code_out, output ready);
endinterface

`default_nettype wire

// File: sv/jct_front.sv
// Front end: accepts input beats, decodes the operation and works out the
// map address (JIS/EUC arithmetic). Depends on jct_pkg and jct_intf.
`default_nettype none

module jct_front
	import jct_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	jct_in_if.sink      in_ch,
	output logic        push_valid,
	input  wire logic   push_ready,
	output entry_t      push_entry
);

	logic   s1_valid_q;
	entry_t entry_s1;
	entry_t entry_d;
	op_t    op;

	// Classify the operation and compute the map address
	always_comb begin
		op               = op_t'(in_ch.operation);
		entry_d.is_write = 1'b0;
		entry_d.use_uni  = 1'b0;
		entry_d.post     = POST_RAW;
		entry_d.addr     = in_ch.code_in;
		entry_d.word     = in_ch.table_word;
		unique case (op)
			OP_WR_SJIS_MAP: begin
				entry_d.is_write = 1'b1;
				entry_d.post     = POST_ZERO;
			end
			OP_WR_UNI_MAP: begin
				entry_d.is_write = 1'b1;
				entry_d.use_uni  = 1'b1;
				entry_d.post     = POST_ZERO;
			end
			OP_SJIS_TO_UNI: begin
			end
			OP_UNI_TO_SJIS: begin
				entry_d.use_uni = 1'b1;
			end
			OP_JIS_TO_UNI: begin
				entry_d.addr = jis_to_sjis(in_ch.code_in);
			end
			OP_UNI_TO_JIS: begin
				entry_d.use_uni = 1'b1;
				entry_d.post    = POST_JIS;
			end
			OP_EUC_TO_UNI: begin
				entry_d.addr = jis_to_sjis(euc_to_jis(in_ch.code_in));
			end
			OP_UNI_TO_EUC: begin
				entry_d.use_uni = 1'b1;
				entry_d.post    = POST_EUC;
			end
		endcase
	end

	// Take a new beat whenever the stage is empty or drains into the queue
	assign in_ch.ready = !s1_valid_q || push_ready;
	assign push_valid  = s1_valid_q;
	assign push_entry  = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ch.ready) begin
			s1_valid_q <= in_ch.valid;
		end
	end

	// Hold the decoded beat
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			entry_s1 <= entry_d;
		end
	end

endmodule

`default_nettype wire

// File: sv/jct_queue.sv
// Short queue of decoded beats between front and back end.
// Depends on jct_pkg.
`default_nettype none

module jct_queue
	import jct_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push_valid,
	output logic        push_ready,
	input  wire entry_t push_entry,
	output logic        pop_valid,
	input  wire logic   pop,
	output entry_t      pop_entry
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the pushed beat
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

`default_nettype wire

// File: sv/jct_back.sv
// Back end: map memories, registered read, SJIS to JIS/EUC fix-up and the
// output register. Depends on jct_pkg and jct_intf.
`default_nettype none

module jct_back
	import jct_pkg::*;
#(
	parameter int unsigned MAP_ENTRIES = MAP_ENTRIES_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   pop_valid,
	output logic        pop,
	input  wire entry_t pop_entry,
	jct_out_if.source   out_ch
);

	localparam int unsigned AW = $clog2(MAP_ENTRIES);

	logic [15:0]   sjis_map [MAP_ENTRIES];
	logic [15:0]   uni_map  [MAP_ENTRIES];
	logic [AW-1:0] addr;

	logic          s2_valid_q;
	logic          use_uni_s2;
	post_t         post_s2;
	logic [15:0]   srd_s2;
	logic [15:0]   urd_s2;

	logic          out_valid_q;
	logic [15:0]   code_out_q;
	logic          out_free;
	logic          s2_adv;
	logic [15:0]   rd_word;
	logic [15:0]   result;

	assign addr     = pop_entry.addr[AW-1:0];
	assign out_free = !out_valid_q || out_ch.ready;
	assign s2_adv   = !s2_valid_q || out_free;
	assign pop      = pop_valid && s2_adv;

	// SJIS to Unicode map: one write or one read per beat
	always_ff @(posedge clk) begin
		if (pop && !pop_entry.use_uni) begin
			if (pop_entry.is_write) begin
				sjis_map[addr] <= pop_entry.word;
			end else begin
				srd_s2 <= sjis_map[addr];
			end
		end
	end

	// Unicode to SJIS map
	always_ff @(posedge clk) begin
		if (pop && pop_entry.use_uni) begin
			if (pop_entry.is_write) begin
				uni_map[addr] <= pop_entry.word;
			end else begin
				urd_s2 <= uni_map[addr];
			end
		end
	end

	// Read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s2_adv) begin
			s2_valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			use_uni_s2 <= pop_entry.use_uni;
			post_s2    <= pop_entry.post;
		end
	end

	// Fix up the word read from the map
	always_comb begin
		rd_word = use_uni_s2 ? urd_s2 : srd_s2;
		unique case (post_s2)
			POST_ZERO: result = 16'h0000;
			POST_RAW:  result = rd_word;
			POST_JIS:  result = sjis_to_jis(rd_word);
			POST_EUC:  result = sjis_to_euc(rd_word);
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s2_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s2_valid_q) begin
			code_out_q <= result;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.code_out = code_out_q;

endmodule

`default_nettype wire

// File: sv/japanese_code_transcoder.sv
// Top level of the Japanese code transcoder: front end, queue, back end.
// Depends on jct_pkg, jct_intf, jct_front, jct_queue and jct_back.
//
//  channel  direction  payload                              beat taken on
//  in_ch    in         operation, code_in, table_word       valid && ready
//  out_ch   out        code_out                             valid && ready
//
// One item per cycle sustained while out_ch is not stalled; each item passes from input
// beat to output beat through decode stage, queue, map read and output register.
// The rate is set by the single port of each map memory, used once per item.
// The maps are not cleared: an entry reads as garbage until written.
// Reset clears only control state. A stall on out_ch fills the queue and
// then drops in_ch.ready; a stall on in_ch leaves the back end draining.
`default_nettype none

module japanese_code_transcoder
	import jct_pkg::*;
#(
	parameter int unsigned MAP_ENTRIES = MAP_ENTRIES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	jct_in_if.sink    in_ch,
	jct_out_if.source out_ch
);

	logic   push_valid;
	logic   push_ready;
	entry_t push_entry;
	logic   pop_valid;
	logic   pop;
	entry_t pop_entry;

	jct_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	jct_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_entry  (pop_entry)
	);

	jct_back #(
		.MAP_ENTRIES (MAP_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_entry (pop_entry),
		.out_ch    (out_ch)
	);

endmodule

`default_nettype wire

// File: sv/jct_chk.sv
// Port-level checks for the transcoder, bound to the top level.
// Depends on jct_pkg.
`default_nettype none

module jct_chk
	import jct_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] code_out
);

	localparam int unsigned PW = $clog2(MAX_INFLIGHT + 2);

	logic [PW-1:0] pending_q;
	logic          in_beat;
	logic          out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// Count items taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_beat && !out_beat) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_beat && !in_beat) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out beat withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(code_out))
		else $error("out payload changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("result offered with no item outstanding");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= PW'(MAX_INFLIGHT))
		else $error("more items in flight than the block can hold");

endmodule

bind japanese_code_transcoder jct_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.code_out  (out_ch.code_out)
);

`default_nettype wire

// File: verif/jct_tb_pkg.sv
`timescale 1ns / 100ps
// Byte-pair conversions between JIS, Shift-JIS and EUC-JP for the transcoder testbench.
// Used by jct_checker to predict results and by tb to find the map entries a conversion reads.
// No dependencies.

package jct_tb_pkg;

	// Full-width JIS code for each half-width katakana, indexed from EUC low byte 0xA0
	localparam logic [15:0] KANA_FULL_WIDTH [64] = '{
		16'h2121, 16'h2123, 16'h2156, 16'h2157, 16'h2122, 16'h2126, 16'h2572, 16'h2521,
		16'h2523, 16'h2525, 16'h2527, 16'h2529, 16'h2563, 16'h2565, 16'h2567, 16'h2543,
		16'h213c, 16'h2522, 16'h2524, 16'h2526, 16'h2528, 16'h252a, 16'h252b, 16'h252d,
		16'h252f, 16'h2531, 16'h2533, 16'h2535, 16'h2537, 16'h2539, 16'h253b, 16'h253d,
		16'h253f, 16'h2541, 16'h2544, 16'h2546, 16'h2548, 16'h254a, 16'h254b, 16'h254c,
		16'h254d, 16'h254e, 16'h254f, 16'h2552, 16'h2555, 16'h2558, 16'h255b, 16'h255e,
		16'h255f, 16'h2560, 16'h2561, 16'h2562, 16'h2564, 16'h2566, 16'h2568, 16'h2569,
		16'h256a, 16'h256b, 16'h256c, 16'h256d, 16'h256f, 16'h2573, 16'h212b, 16'h212c
	};

	// JIS row/column pair to SJIS lead/trail pair; all byte sums wrap at 8 bits
	function automatic logic [15:0] jis_pair_to_sjis(input logic [15:0] jis);
		logic [7:0] row;
		logic [7:0] col;
		logic [7:0] half;
		row = jis[15:8];
		col = jis[7:0] + (row[0] ? 8'h1f : 8'h7d);
		if (col >= 8'h7f) begin
			col = col + 8'h01;
		end
		half = row - 8'h21;
		row  = (half >> 1) + 8'h81;
		if (row > 8'h9f) begin
			row = row + 8'h40;
		end
		return {row, col};
	endfunction

	// SJIS lead byte to the odd JIS row it starts
	function automatic logic [7:0] sjis_lead_row(input logic [7:0] lead);
		logic [7:0] base;
		base = lead - ((lead <= 8'h9f) ? 8'h71 : 8'hb1);
		return (base << 1) + 8'h01;
	endfunction

	function automatic logic [15:0] sjis_pair_to_jis(input logic [15:0] sjis);
		logic [7:0] row;
		logic [7:0] col;
		row = sjis_lead_row(sjis[15:8]);
		col = sjis[7:0];
		if (col > 8'h7f) begin
			col = col - 8'h01;
		end
		if (col >= 8'h9e) begin
			col = col - 8'h7d;
			row = row + 8'h01;
		end else begin
			col = col - 8'h1f;
		end
		return {row, col};
	endfunction

	// Trail byte 0x9F and up moves to the even row; 0x9E stays on the odd one
	function automatic logic [15:0] sjis_pair_to_euc(input logic [15:0] sjis);
		logic [7:0] row;
		logic [7:0] col;
		row = sjis_lead_row(sjis[15:8]);
		col = sjis[7:0];
		if (col >= 8'h9f) begin
			col = col - 8'h7e;
			row = row + 8'h01;
		end else if (col > 8'h7f) begin
			col = col - 8'h20;
		end else begin
			col = col - 8'h1f;
		end
		return {row | 8'h80, col | 8'h80};
	endfunction

	// EUC-JP to JIS; an 0x8E prefix selects katakana, and an out-of-range kana gives 0
	function automatic logic [15:0] euc_pair_to_jis(input logic [15:0] euc);
		logic [7:0] idx;
		idx = euc[7:0] - 8'ha0;
		if (euc[15:8] == 8'h8e) begin
			if (euc[7:0] < 8'ha0 || euc[7:0] > 8'hdf) begin
				return 16'h0000;
			end
			return KANA_FULL_WIDTH[idx[5:0]];
		end
		return euc & 16'h7f7f;
	endfunction

endpackage

// File: verif/jct_checker.sv
`timescale 1ns / 100ps
// Watches both transcoder channels, keeps its own copy of the two map memories and
// compares every output beat with the code predicted for the oldest accepted item.
// Depends on jct_pkg, jct_intf and jct_tb_pkg.

module jct_checker
	import jct_pkg::*;
	import jct_tb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	jct_in_if    in_ch,
	jct_out_if   out_ch,
	output int   fail_count,
	output int   pending,
	output int   results_checked
);

	typedef struct {
		op_t         op;
		logic [15:0] code;
		logic [15:0] code_out;
	} awaited_code_t;

	logic [15:0]   sjis_to_uni_store [65536];
	logic [15:0]   uni_to_sjis_store [65536];
	awaited_code_t awaited_codes [$];

	// Code the block should return for one item, given the maps as they stand
	function automatic logic [15:0] converted_code(op_t op, logic [15:0] code);
		case (op)
			OP_SJIS_TO_UNI: return sjis_to_uni_store[code];
			OP_UNI_TO_SJIS: return uni_to_sjis_store[code];
			OP_JIS_TO_UNI:  return sjis_to_uni_store[jis_pair_to_sjis(code)];
			OP_UNI_TO_JIS:  return sjis_pair_to_jis(uni_to_sjis_store[code]);
			OP_EUC_TO_UNI:  return sjis_to_uni_store[jis_pair_to_sjis(euc_pair_to_jis(code))];
			OP_UNI_TO_EUC:  return sjis_pair_to_euc(uni_to_sjis_store[code]);
			default:        return 16'h0000;
		endcase
	endfunction

	// Predict on each input beat, compare on each output beat
	always @(posedge clk or negedge arst_n) begin
		awaited_code_t item;
		awaited_code_t want;
		if (!arst_n) begin
			awaited_codes.delete();
			fail_count      = 0;
			results_checked = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				item.op   = op_t'(in_ch.operation);
				item.code = in_ch.code_in;
				case (item.op)
					OP_WR_SJIS_MAP: sjis_to_uni_store[item.code] = in_ch.table_word;
					OP_WR_UNI_MAP:  uni_to_sjis_store[item.code] = in_ch.table_word;
					default: ;
				endcase
				item.code_out = converted_code(item.op, item.code);
				awaited_codes.push_back(item);
			end
			if (out_ch.valid && out_ch.ready) begin
				if (awaited_codes.size() == 0) begin
					fail_count++;
					$error("code_out beat %h with no item outstanding", out_ch.code_out);
				end else begin
					want = awaited_codes.pop_front();
					results_checked++;
					if (out_ch.code_out !== want.code_out) begin
						fail_count++;
						$error("code_out mismatch (%s of %h): expected %h, actual %h",
							want.op.name(), want.code, want.code_out, out_ch.code_out);
					end
				end
			end
		end
		pending = awaited_codes.size();
	end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Testbench top for japanese_code_transcoder: clock, reset, input beats and output stalls.
// Depends on jct_pkg, jct_intf, jct_tb_pkg, jct_checker and the transcoder RTL.

module tb;
	import jct_pkg::*;
	import jct_tb_pkg::*;

	localparam int RANDOM_ITEMS    = 1600;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int DRAIN_CYCLES    = 16;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   results_checked;

	jct_in_if  in_ch();
	jct_out_if out_ch();

	japanese_code_transcoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	jct_checker i_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_ch           (in_ch),
		.out_ch          (out_ch),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked)
	);

	int          send_idle_pct;
	int          stall_pct;
	bit          hold_off_req;
	int          quiet_cycles;
	int          items_sent;
	int          op_tally [8];
	bit          sjis_entry_loaded [65536];
	bit          uni_entry_loaded [65536];
	logic [15:0] sjis_loaded_addrs [$];
	logic [15:0] uni_loaded_addrs [$];

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Plausible SJIS code: lead in either kanji block, trail over the whole trail range
	function automatic logic [15:0] sjis_like_code();
		logic [7:0] lead;
		logic [7:0] trail;
		lead  = $urandom_range(1) ? 8'($urandom_range(8'h81, 8'h9f))
			: 8'($urandom_range(8'he0, 8'hef));
		trail = 8'($urandom_range(8'h40, 8'hfc));
		return {lead, trail};
	endfunction

	function automatic logic [15:0] pick_word(op_t op);
		if (op == OP_WR_UNI_MAP && $urandom_range(1))
			return sjis_like_code();
		return 16'($urandom);
	endfunction

	// Mix of revisited entries, well-formed codes and raw noise for each operation
	function automatic logic [15:0] pick_code(op_t op);
		int roll;
		roll = $urandom_range(9);
		case (op)
			OP_WR_SJIS_MAP, OP_SJIS_TO_UNI: begin
				if (roll < 3 && sjis_loaded_addrs.size() != 0)
					return sjis_loaded_addrs[$urandom_range(sjis_loaded_addrs.size() - 1)];
				if (roll < 6)
					return sjis_like_code();
			end
			OP_JIS_TO_UNI: begin
				if (roll < 5)
					return {8'($urandom_range(8'h21, 8'h7e)), 8'($urandom_range(8'h21, 8'h7e))};
			end
			OP_EUC_TO_UNI: begin
				if (roll < 3)
					return {8'h8e, 8'($urandom)};
				if (roll < 7)
					return {8'($urandom_range(8'ha1, 8'hfe)), 8'($urandom_range(8'ha1, 8'hfe))};
			end
			default: begin
				if (roll < 4 && uni_loaded_addrs.size() != 0)
					return uni_loaded_addrs[$urandom_range(uni_loaded_addrs.size() - 1)];
			end
		endcase
		return 16'($urandom);
	endfunction

	// Offer one beat, with random idle cycles ahead of it, and hold it until taken
	task automatic offer_beat(op_t op, logic [15:0] code, logic [15:0] word);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.operation  <= op;
		in_ch.code_in    <= code;
		in_ch.table_word <= word;
		do @(posedge clk); while (!in_ch.ready);
		op_tally[op]++;
		items_sent++;
		if (op == OP_WR_SJIS_MAP && !sjis_entry_loaded[code]) begin
			sjis_entry_loaded[code] = 1'b1;
			sjis_loaded_addrs.push_back(code);
		end
		if (op == OP_WR_UNI_MAP && !uni_entry_loaded[code]) begin
			uni_entry_loaded[code] = 1'b1;
			uni_loaded_addrs.push_back(code);
		end
	endtask

	// Send one item, first loading the map entry a conversion reads if it is still unwritten
	task automatic request(op_t op, logic [15:0] code, logic [15:0] word);
		logic [15:0] addr;
		case (op)
			OP_JIS_TO_UNI: addr = jis_pair_to_sjis(code);
			OP_EUC_TO_UNI: addr = jis_pair_to_sjis(euc_pair_to_jis(code));
			default:       addr = code;
		endcase
		if (op inside {OP_SJIS_TO_UNI, OP_JIS_TO_UNI, OP_EUC_TO_UNI} && !sjis_entry_loaded[addr])
			offer_beat(OP_WR_SJIS_MAP, addr, pick_word(OP_WR_SJIS_MAP));
		else if (op inside {OP_UNI_TO_SJIS, OP_UNI_TO_JIS, OP_UNI_TO_EUC} &&
			!uni_entry_loaded[addr])
			offer_beat(OP_WR_UNI_MAP, addr, pick_word(OP_WR_UNI_MAP));
		offer_beat(op, code, word);
	endtask

	// Output side: random stalls, plus one long hold-off on request
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ch.ready <= 1'b0;
				for (int n = 0; n < HOLD_OFF_CYCLES; n++)
					@(posedge clk);
			end else begin
				out_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Abort when neither channel moves a beat for too long
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int   target;
		op_t  op;
		arst_n           <= 1'b0;
		in_ch.valid      <= 1'b0;
		in_ch.operation  <= OP_WR_SJIS_MAP;
		in_ch.code_in    <= 16'h0000;
		in_ch.table_word <= 16'h0000;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_off_req  = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme indexes and words, every direction, kana edges, trail 0x9E/0x9F
		request(OP_WR_SJIS_MAP, 16'h0000, 16'hffff);
		request(OP_WR_SJIS_MAP, 16'hffff, 16'h0000);
		request(OP_WR_UNI_MAP,  16'h0000, 16'h889e);
		request(OP_WR_UNI_MAP,  16'h0001, 16'h889f);
		request(OP_WR_UNI_MAP,  16'hffff, 16'hffff);
		request(OP_SJIS_TO_UNI, 16'h0000, 16'hffff);
		request(OP_SJIS_TO_UNI, 16'hffff, 16'h0000);
		request(OP_UNI_TO_SJIS, 16'hffff, 16'h0000);
		request(OP_JIS_TO_UNI,  16'h2121, 16'h0000);
		request(OP_JIS_TO_UNI,  16'hffff, 16'h0000);
		request(OP_UNI_TO_JIS,  16'h0000, 16'h0000);
		request(OP_UNI_TO_JIS,  16'hffff, 16'h0000);
		request(OP_EUC_TO_UNI,  16'h8ea0, 16'h0000);
		request(OP_EUC_TO_UNI,  16'h8edf, 16'h0000);
		request(OP_EUC_TO_UNI,  16'h8e9f, 16'h0000);
		request(OP_EUC_TO_UNI,  16'h8ee0, 16'h0000);
		request(OP_EUC_TO_UNI,  16'hb0a1, 16'h0000);
		request(OP_UNI_TO_EUC,  16'h0000, 16'h0000);
		request(OP_UNI_TO_EUC,  16'h0001, 16'h0000);
		request(OP_UNI_TO_EUC,  16'hffff, 16'h0000);

		// Random: no idling with a long output hold-off, input gaps, output stalls, both
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  hold_off_req = 1'b1; end
				1: begin send_idle_pct = 57; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 57; end
				default: begin send_idle_pct = 25; stall_pct = 25; end
			endcase
			target = items_sent + RANDOM_ITEMS / 4;
			while (items_sent < target) begin
				op = op_t'($urandom_range(7));
				request(op, pick_code(op), pick_word(op));
			end
		end
		in_ch.valid <= 1'b0;

		// Wait until the checker has no item outstanding, then allow for any stray output
		stall_pct = 0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items: %0d SJIS map writes, %0d Unicode map writes, %0d conversions.",
			items_sent, op_tally[OP_WR_SJIS_MAP], op_tally[OP_WR_UNI_MAP],
			items_sent - op_tally[OP_WR_SJIS_MAP] - op_tally[OP_WR_UNI_MAP]);
		$display("Compared %0d codes under input gaps, output stalls and a %0d-cycle hold-off.",
			results_checked, HOLD_OFF_CYCLES);
		if (pending != 0)
			$error("%0d items never delivered", pending);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
